// ----- rtl/adcmv_pkg.sv -----
// Package with the constants and derived widths of the ADC average millivolt converter.
package adcmv_pkg;

   localparam int SAMPLES_PER_GROUP = 16;
   localparam int SAMPLE_BITS       = 12;
   localparam int MV_W              = 11;
   localparam int RES_W             = 16;

   localparam logic [MV_W-1:0] BANDGAP_MV_RESET = MV_W'(1190);

   localparam int CNT_W      = $clog2(SAMPLES_PER_GROUP + 1);
   localparam int SUM_W      = SAMPLE_BITS + $clog2(SAMPLES_PER_GROUP);
   localparam int DIVIDEND_W = MV_W + SAMPLE_BITS;
   localparam int ACC_W      = RES_W + SAMPLE_BITS;
   localparam int UNIT_W     = RES_W + 1;
   localparam int STEP_W     = $clog2(DIVIDEND_W);

   localparam logic [CNT_W-1:0]  GROUP_LAST = CNT_W'(SAMPLES_PER_GROUP);
   localparam logic [STEP_W-1:0] DIV_LAST   = STEP_W'(DIVIDEND_W - 1);
   localparam logic [STEP_W-1:0] MUL_LAST   = STEP_W'(SAMPLE_BITS - 1);

   localparam logic SOURCE_CHANNEL = 1'b0;
   localparam logic SOURCE_BANDGAP = 1'b1;

endpackage

// ----- rtl/adc_average_millivolt_convert.sv -----
// Top level of the ADC average millivolt converter: group averaging, divide and scale.
//
// Each source keeps its own group: the first sample after a group is dropped and the next
// sixteen are summed and averaged. A channel sample is taken without leaving idle and never
// yields a transfer on the result side. A bandgap sample that completes its group starts the
// supply computation, bandgap_mv * 4096 / average, on a bit-serial restoring divider, followed
// by a saturation step and, when a channel average is pending, a shift-add multiply for the
// channel voltage; both run on one shared 17-bit adder. Such an item therefore holds the input
// stalled through the divide, the saturation step and any multiply, and then until the
// previous result has been taken and its own result is registered. The bandgap_mv register
// must only be written while the block is idle.
module adc_average_millivolt_convert (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [adcmv_pkg::SAMPLE_BITS-1:0]    req_sample,
   input  logic                                 req_source,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [adcmv_pkg::RES_W-1:0]          rsp_supply_mv,
   output logic [adcmv_pkg::RES_W-1:0]          rsp_channel_mv,
   output logic                                 rsp_channel_valid,
   input  logic                                 csr_write,
   input  logic [adcmv_pkg::MV_W-1:0]           csr_wdata
);

   localparam int SB  = adcmv_pkg::SAMPLE_BITS;
   localparam int DW  = adcmv_pkg::DIVIDEND_W;
   localparam int AW  = adcmv_pkg::ACC_W;
   localparam int UW  = adcmv_pkg::UNIT_W;
   localparam int RW  = adcmv_pkg::RES_W;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_DIV  = 3'd1;
   localparam logic [2:0] ST_FIN  = 3'd2;
   localparam logic [2:0] ST_MUL  = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   logic [2:0]                         state_ff, state_in;
   logic [adcmv_pkg::MV_W-1:0]         bandgap_mv_ff;
   logic [adcmv_pkg::SUM_W-1:0]        ch_sum_ff, ch_sum_in, bg_sum_ff, bg_sum_in;
   logic [adcmv_pkg::CNT_W-1:0]        ch_count_ff, ch_count_in, bg_count_ff, bg_count_in;
   logic [SB-1:0]                      ch_avg_ff, ch_avg_in;
   logic                               ch_ready_ff, ch_ready_in;
   logic [SB-1:0]                      divisor_ff, divisor_in;
   logic                               zero_ff, zero_in;
   logic                               chv_ff, chv_in;
   logic [DW-1:0]                      quo_ff, quo_in;
   logic [SB-1:0]                      rem_ff, rem_in;
   logic [AW-1:0]                      acc_ff, acc_in;
   logic [RW-1:0]                      supply_ff, supply_in;
   logic [adcmv_pkg::STEP_W-1:0]       step_ff, step_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [RW-1:0]                      rsp_supply_ff, rsp_supply_in;
   logic [RW-1:0]                      rsp_channel_ff, rsp_channel_in;
   logic                               rsp_chv_ff, rsp_chv_in;

   logic                               accept;
   logic [adcmv_pkg::SUM_W-1:0]        cur_sum, new_sum;
   logic [adcmv_pkg::CNT_W-1:0]        cur_count;
   logic                               group_done;
   logic [SB-1:0]                      group_avg;
   logic [SB:0]                        rem_shift;
   logic [UW-1:0]                      unit_a, unit_b;
   logic                               unit_cin;
   logic [UW:0]                        unit_sum;
   logic                               out_free;

   assign req_stall         = (state_ff != ST_IDLE);
   assign accept            = req_valid && !req_stall;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_supply_mv     = rsp_supply_ff;
   assign rsp_channel_mv    = rsp_channel_ff;
   assign rsp_channel_valid = rsp_chv_ff;
   assign out_free          = !rsp_valid_ff || !rsp_stall;

   assign cur_sum    = (req_source == adcmv_pkg::SOURCE_BANDGAP) ? bg_sum_ff : ch_sum_ff;
   assign cur_count  = (req_source == adcmv_pkg::SOURCE_BANDGAP) ? bg_count_ff : ch_count_ff;
   assign new_sum    = cur_sum + adcmv_pkg::SUM_W'(req_sample);
   assign group_done = (cur_count == adcmv_pkg::GROUP_LAST);
   assign group_avg  = SB'(new_sum / adcmv_pkg::SAMPLES_PER_GROUP);
   assign rem_shift  = {rem_ff, quo_ff[DW-1]};

   // The shared adder subtracts the divisor while dividing and adds the partial product
   // while multiplying.
   always_comb begin
      if (state_ff == ST_MUL) begin
         unit_a   = UW'(acc_ff[AW-1:SB]);
         unit_b   = acc_ff[0] ? UW'(supply_ff) : '0;
         unit_cin = 1'b0;
      end else begin
         unit_a   = UW'(rem_shift);
         unit_b   = ~UW'(divisor_ff);
         unit_cin = 1'b1;
      end
      unit_sum = {1'b0, unit_a} + {1'b0, unit_b} + (UW + 1)'(unit_cin);
   end

   always_comb begin
      state_in       = state_ff;
      ch_sum_in      = ch_sum_ff;
      bg_sum_in      = bg_sum_ff;
      ch_count_in    = ch_count_ff;
      bg_count_in    = bg_count_ff;
      ch_avg_in      = ch_avg_ff;
      ch_ready_in    = ch_ready_ff;
      divisor_in     = divisor_ff;
      zero_in        = zero_ff;
      chv_in         = chv_ff;
      quo_in         = quo_ff;
      rem_in         = rem_ff;
      acc_in         = acc_ff;
      supply_in      = supply_ff;
      step_in        = step_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_supply_in  = rsp_supply_ff;
      rsp_channel_in = rsp_channel_ff;
      rsp_chv_in     = rsp_chv_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_source == adcmv_pkg::SOURCE_CHANNEL) begin
                  if (ch_count_ff == '0) begin
                     ch_count_in = adcmv_pkg::CNT_W'(1);
                     ch_sum_in   = '0;
                  end else if (group_done) begin
                     ch_count_in = '0;
                     ch_sum_in   = '0;
                     ch_avg_in   = group_avg;
                     ch_ready_in = 1'b1;
                  end else begin
                     ch_count_in = ch_count_ff + adcmv_pkg::CNT_W'(1);
                     ch_sum_in   = new_sum;
                  end
               end else begin
                  if (bg_count_ff == '0) begin
                     bg_count_in = adcmv_pkg::CNT_W'(1);
                     bg_sum_in   = '0;
                  end else if (group_done) begin
                     bg_count_in = '0;
                     bg_sum_in   = '0;
                     divisor_in  = group_avg;
                     zero_in     = (group_avg == '0);
                     chv_in      = ch_ready_ff;
                     ch_ready_in = 1'b0;
                     quo_in      = {bandgap_mv_ff, {SB{1'b0}}};
                     rem_in      = '0;
                     step_in     = '0;
                     state_in    = ST_DIV;
                  end else begin
                     bg_count_in = bg_count_ff + adcmv_pkg::CNT_W'(1);
                     bg_sum_in   = new_sum;
                  end
               end
            end
         end
         ST_DIV: begin
            quo_in  = {quo_ff[DW-2:0], unit_sum[UW]};
            rem_in  = unit_sum[UW] ? unit_sum[SB-1:0] : rem_shift[SB-1:0];
            step_in = step_ff + adcmv_pkg::STEP_W'(1);
            if (step_ff == adcmv_pkg::DIV_LAST) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (zero_ff) begin
               supply_in = '0;
            end else if (|quo_ff[DW-1:RW]) begin
               supply_in = '1;
            end else begin
               supply_in = quo_ff[RW-1:0];
            end
            acc_in   = AW'(ch_avg_ff);
            step_in  = '0;
            state_in = chv_ff ? ST_MUL : ST_DONE;
         end
         ST_MUL: begin
            acc_in  = {unit_sum[RW:0], acc_ff[SB-1:1]};
            step_in = step_ff + adcmv_pkg::STEP_W'(1);
            if (step_ff == adcmv_pkg::MUL_LAST) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_supply_in  = supply_ff;
               rsp_channel_in = chv_ff ? acc_ff[AW-1:SB] : '0;
               rsp_chv_in     = chv_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         bandgap_mv_ff <= adcmv_pkg::BANDGAP_MV_RESET;
         ch_sum_ff     <= '0;
         bg_sum_ff     <= '0;
         ch_count_ff   <= '0;
         bg_count_ff   <= '0;
         ch_avg_ff     <= '0;
         ch_ready_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         step_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         if (csr_write) begin
            bandgap_mv_ff <= csr_wdata;
         end
         ch_sum_ff    <= ch_sum_in;
         bg_sum_ff    <= bg_sum_in;
         ch_count_ff  <= ch_count_in;
         bg_count_ff  <= bg_count_in;
         ch_avg_ff    <= ch_avg_in;
         ch_ready_ff  <= ch_ready_in;
         rsp_valid_ff <= rsp_valid_in;
         step_ff      <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      divisor_ff     <= divisor_in;
      zero_ff        <= zero_in;
      chv_ff         <= chv_in;
      quo_ff         <= quo_in;
      rem_ff         <= rem_in;
      acc_ff         <= acc_in;
      supply_ff      <= supply_in;
      rsp_supply_ff  <= rsp_supply_in;
      rsp_channel_ff <= rsp_channel_in;
      rsp_chv_ff     <= rsp_chv_in;
   end

endmodule

// ----- test/tb.sv -----
// Testbench for the ADC average millivolt converter: random groups, prediction and checking.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SAMPLES_PER_GROUP = adcmv_pkg::SAMPLES_PER_GROUP;
   localparam int SAMPLE_BITS       = adcmv_pkg::SAMPLE_BITS;
   localparam int MV_W              = adcmv_pkg::MV_W;
   localparam int RES_W             = adcmv_pkg::RES_W;
   localparam int SUM_W             = adcmv_pkg::SUM_W;
   localparam int CNT_W             = adcmv_pkg::CNT_W;
   localparam logic SOURCE_CHANNEL  = adcmv_pkg::SOURCE_CHANNEL;
   localparam logic SOURCE_BANDGAP  = adcmv_pkg::SOURCE_BANDGAP;
   localparam logic [MV_W-1:0] BANDGAP_MV_RESET = adcmv_pkg::BANDGAP_MV_RESET;

   localparam int SETTLE_CYCLES = 60;
   localparam int STUCK_LIMIT   = 3000;
   localparam int HOLD_CYCLES   = 400;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] sample;
      logic                   source;
   } adc_sample_type;

   typedef struct packed {
      logic [RES_W-1:0] supply_mv;
      logic [RES_W-1:0] channel_mv;
      logic             channel_valid;
   } reading_type;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic [SAMPLE_BITS-1:0] req_sample;
   logic                   req_source;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic [RES_W-1:0]       rsp_supply_mv;
   logic [RES_W-1:0]       rsp_channel_mv;
   logic                   rsp_channel_valid;
   logic                   csr_write;
   logic [MV_W-1:0]        csr_wdata;

   adc_sample_type sample_queue[$];
   reading_type    expected_readings[$];
   adc_sample_type next_sample;
   reading_type    got_reading;
   reading_type    want_reading;
   logic        req_taken;
   int          n_pushed;
   int          n_accepted;
   int          errors;
   int          send_idle_pct;
   int          rsp_stall_pct;
   int          hold_left;
   int          stuck_cycles;

   // Shadow copy of the converter state.
   logic [MV_W-1:0]        mv_setting;
   logic [SUM_W-1:0]       chan_sum;
   logic [SUM_W-1:0]       bg_sum;
   logic [CNT_W-1:0]       chan_cnt;
   logic [CNT_W-1:0]       bg_cnt;
   logic [SAMPLE_BITS-1:0] chan_avg;
   logic                   chan_ready;

   adc_average_millivolt_convert u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_sample        (req_sample),
      .req_source        (req_source),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_supply_mv     (rsp_supply_mv),
      .rsp_channel_mv    (rsp_channel_mv),
      .rsp_channel_valid (rsp_channel_valid),
      .csr_write         (csr_write),
      .csr_wdata         (csr_wdata)
   );

   always #4 clock = ~clock;

   task automatic predict_conversion(input logic [SAMPLE_BITS-1:0] s, input logic src);
      logic [31:0] avg;
      logic [31:0] supply;
      logic [31:0] scaled;
      reading_type r;
      if (src == SOURCE_CHANNEL) begin
         if (chan_cnt == '0) begin
            chan_cnt = CNT_W'(1);
            chan_sum = '0;
         end else begin
            chan_sum = chan_sum + SUM_W'(s);
            chan_cnt = chan_cnt + CNT_W'(1);
            if (chan_cnt >= CNT_W'(SAMPLES_PER_GROUP + 1)) begin
               chan_avg = SAMPLE_BITS'(chan_sum / SAMPLES_PER_GROUP);
               chan_sum = '0;
               chan_cnt = '0;
               chan_ready = 1'b1;
            end
         end
      end else begin
         if (bg_cnt == '0) begin
            bg_cnt = CNT_W'(1);
            bg_sum = '0;
         end else begin
            bg_sum = bg_sum + SUM_W'(s);
            bg_cnt = bg_cnt + CNT_W'(1);
            if (bg_cnt >= CNT_W'(SAMPLES_PER_GROUP + 1)) begin
               avg = 32'(bg_sum / SAMPLES_PER_GROUP);
               bg_sum = '0;
               bg_cnt = '0;
               supply = '0;
               if (avg != 0) begin
                  supply = (32'(mv_setting) << SAMPLE_BITS) / avg;
                  if (supply > 32'd65535) supply = 32'd65535;
               end
               scaled = '0;
               r.channel_valid = 1'b0;
               if (chan_ready) begin
                  scaled = (32'(chan_avg) * supply) >> SAMPLE_BITS;
                  if (scaled > 32'd65535) scaled = 32'd65535;
                  r.channel_valid = 1'b1;
                  chan_ready = 1'b0;
               end
               r.supply_mv = RES_W'(supply);
               r.channel_mv = RES_W'(scaled);
               expected_readings.push_back(r);
            end
         end
      end
   endtask

   always @(posedge clock) begin
      req_taken <= 1'b0;
      if (!reset && req_valid && !req_stall) begin
         req_taken <= 1'b1;
         predict_conversion(req_sample, req_source);
         n_accepted++;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (sample_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            next_sample = sample_queue.pop_front();
            req_valid  <= 1'b1;
            req_sample <= next_sample.sample;
            req_source <= next_sample.source;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         got_reading.supply_mv     = rsp_supply_mv;
         got_reading.channel_mv    = rsp_channel_mv;
         got_reading.channel_valid = rsp_channel_valid;
         if (expected_readings.size() == 0) begin
            $error("unexpected result transfer: supply_mv %0d", rsp_supply_mv);
            errors++;
         end else begin
            want_reading = expected_readings.pop_front();
            if (got_reading.supply_mv !== want_reading.supply_mv) begin
               $error("supply_mv expected %0d got %0d",
                      want_reading.supply_mv, got_reading.supply_mv);
               errors++;
            end
            if (got_reading.channel_mv !== want_reading.channel_mv) begin
               $error("channel_mv expected %0d got %0d",
                      want_reading.channel_mv, got_reading.channel_mv);
               errors++;
            end
            if (got_reading.channel_valid !== want_reading.channel_valid) begin
               $error("channel_valid expected %0d got %0d",
                      want_reading.channel_valid, got_reading.channel_valid);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         stuck_cycles = 0;
      end else begin
         stuck_cycles++;
      end
      if (stuck_cycles >= STUCK_LIMIT) begin
         $display("tb: done, errors");
         $finish;
      end
   end

   task automatic push_item(input logic [SAMPLE_BITS-1:0] s, input logic src);
      adc_sample_type item;
      item.sample = s;
      item.source = src;
      sample_queue.push_back(item);
      n_pushed++;
   endtask

   task automatic add_group(input logic src, input bit interleave);
      int kind;
      int base;
      int v;
      kind = $urandom_range(9);
      base = $urandom_range(4095);
      if (kind == 1) base = $urandom_range(120);
      if (kind == 2) base = $urandom_range(4095, 4030);
      push_item(SAMPLE_BITS'($urandom_range(4095)), src);
      for (int i = 0; i < SAMPLES_PER_GROUP; i++) begin
         if (kind == 0) begin
            v = $urandom_range(1);
         end else if (kind == 3) begin
            v = $urandom_range(4095);
         end else begin
            v = base + $urandom_range(126) - 63;
            if (v < 0) v = 0;
            if (v > 4095) v = 4095;
         end
         push_item(SAMPLE_BITS'(v), src);
         if (interleave && $urandom_range(6) == 0) begin
            push_item(SAMPLE_BITS'($urandom_range(4095)), !src);
         end
      end
   endtask

   task automatic random_items(input int count);
      int start;
      int mode;
      int k;
      start = n_pushed;
      while (n_pushed - start < count) begin
         mode = $urandom_range(9);
         if (mode < 7) begin
            if ($urandom_range(1)) add_group(SOURCE_CHANNEL, $urandom_range(4) == 0);
            add_group(SOURCE_BANDGAP, $urandom_range(4) == 0);
         end else if (mode == 7) begin
            add_group(SOURCE_CHANNEL, 1'b0);
            add_group(SOURCE_CHANNEL, 1'b0);
            add_group(SOURCE_BANDGAP, 1'b0);
         end else if (mode == 8) begin
            add_group(SOURCE_BANDGAP, 1'b1);
         end else begin
            k = $urandom_range(5, 1);
            repeat (k) push_item(SAMPLE_BITS'($urandom_range(4095)), 1'($urandom_range(1)));
         end
      end
   endtask

   task automatic drain();
      while (n_accepted != n_pushed || expected_readings.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_bandgap_mv(input logic [MV_W-1:0] value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_write <= 1'b0;
      mv_setting = value;
   endtask

   task automatic run_phase(input logic [MV_W-1:0] mv, input int idle, input int stall,
                            input int count);
      drain();
      write_bandgap_mv(mv);
      @(posedge clock);
      send_idle_pct = idle;
      rsp_stall_pct = stall;
      random_items(count);
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_sample = '0;
      req_source = 1'b0;
      rsp_stall = 1'b0;
      csr_write = 1'b0;
      csr_wdata = '0;
      req_taken = 1'b0;
      n_pushed = 0;
      n_accepted = 0;
      errors = 0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      hold_left = 0;
      stuck_cycles = 0;
      mv_setting = BANDGAP_MV_RESET;
      chan_sum = '0;
      bg_sum = '0;
      chan_cnt = '0;
      bg_cnt = '0;
      chan_avg = '0;
      chan_ready = 1'b0;

      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // A zero bandgap average with channel samples woven in and no channel group finished.
      push_item(SAMPLE_BITS'(4095), SOURCE_CHANNEL);
      push_item(SAMPLE_BITS'(4095), SOURCE_BANDGAP);
      for (int i = 0; i < SAMPLES_PER_GROUP; i++) begin
         push_item('0, SOURCE_BANDGAP);
         if (i < 6) push_item((i % 2 == 0) ? SAMPLE_BITS'(4095) : '0, SOURCE_CHANNEL);
      end
      random_items(250);

      run_phase(MV_W'(1000), 66, 0, 250);
      run_phase(MV_W'(1400), 0, 66, 250);
      run_phase(MV_W'($urandom_range(1400, 1000)), 33, 33, 250);

      // The receiver holds off while the sender keeps offering, so the block backs up.
      drain();
      write_bandgap_mv(MV_W'($urandom_range(1400, 1000)));
      @(posedge clock);
      send_idle_pct = 0;
      rsp_stall_pct = 20;
      hold_left = HOLD_CYCLES;
      repeat (3) begin
         add_group(SOURCE_CHANNEL, 1'b0);
         add_group(SOURCE_BANDGAP, 1'b0);
      end

      drain();
      if (expected_readings.size() != 0) begin
         $error("%0d expected results never arrived", expected_readings.size());
         errors++;
      end
      if (errors == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule
